>>> design/gimbal_aim_angle_speed_split_top_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the gimbal aim block
// Each macro expands to a concurrent assertion in simulation and to nothing
// when SYNTHESIS is defined. The clock is clk and the reset is arst_n.
// ----------------------------------------------------------------------------
`ifndef GIMBAL_AIM_ANGLE_SPEED_SPLIT_TOP_MACROS_SVH
`define GIMBAL_AIM_ANGLE_SPEED_SPLIT_TOP_MACROS_SVH
`ifndef SYNTHESIS
// Same-cycle implication.
`define GAAS_ASSERT_IMP(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("assertion failed");
// Next-cycle implication.
`define GAAS_ASSERT_NXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("assertion failed");
`else
`define GAAS_ASSERT_IMP(lbl, ante, cons)
`define GAAS_ASSERT_NXT(lbl, ante, cons)
`endif
`endif

>>> design/gaas_pkg.sv
// ----------------------------------------------------------------------------
// Gimbal aim package
// Types, constants and the arctangent table shared by the gimbal aim block.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package gaas_pkg;

	// Field widths.
	localparam int CoordW = 20;
	localparam int SpeedW = 16;
	localparam int AngleW = 16;
	localparam int CfgAddrW = 2;
	localparam int CfgDataW = 20;

	// Register indexes of the configuration port.
	localparam logic [CfgAddrW-1:0] REG_PLANE_DIST  = 2'd0;
	localparam logic [CfgAddrW-1:0] REG_BASE_SPEED  = 2'd1;
	localparam logic [CfgAddrW-1:0] REG_YAW_INIT    = 2'd2;
	localparam logic [CfgAddrW-1:0] REG_PITCH_INIT  = 2'd3;

	localparam logic [CoordW-1:0] PLANE_DIST_RESET = 20'd256;

	// Iteration counts (last index of each loop).
	localparam logic [4:0] SQRT_LAST   = 5'd28;
	localparam logic [4:0] CORDIC_LAST = 5'd19;
	localparam logic [4:0] DIV_LAST    = 5'd15;

	localparam logic signed [22:0] ANG_LIMIT = 23'sd25736;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_MUL_A,
		ST_MUL_B,
		ST_MUL_SUM,
		ST_SQRT,
		ST_CORDIC,
		ST_ANG_DONE,
		ST_SPD_MUL,
		ST_DIV_LD,
		ST_DIV,
		ST_FIN
	} state_t;

	typedef enum logic [1:0] {
		JOB_YAW,
		JOB_PITCH,
		JOB_SPEED
	} job_t;

	// atan(2^-i) in Q.20, rounded; exact powers of two from i = 7 on.
	function automatic logic [19:0] atan_q20(input logic [4:0] i);
		logic [19:0] t;
		case (i)
			5'd0: t = 20'd823550;
			5'd1: t = 20'd486170;
			5'd2: t = 20'd256879;
			5'd3: t = 20'd130396;
			5'd4: t = 20'd65451;
			5'd5: t = 20'd32757;
			5'd6: t = 20'd16383;
			default: t = 20'd1 << (5'd20 - i);
		endcase
		return t;
	endfunction

endpackage

>>> design/gimbal_aim_angle_speed_split_top.sv
// ----------------------------------------------------------------------------
// Gimbal aim angle and speed split
// Turns a target point into yaw and pitch angles and splits a base speed
// between the two axes by the move from the previous point.
// ----------------------------------------------------------------------------
// Usage:
// An input transfer on s_* carries target_x and target_y (signed 12.8). Each
// input gives exactly one result transfer on m_* with yaw_angle, pitch_angle
// (Q2.14 radians) and yaw_speed, pitch_speed. Registers are written through
// cfg_we / cfg_addr / cfg_wdata; the user must write them only while the block
// is idle, which the block itself does not enforce. Each item works out both
// angles; when the point has moved, it also takes the length of the move and
// splits the base speed. When the plane distance and the point are both zero,
// the CORDIC is skipped for both angles. s_tready is high only in the idle
// state. The work is done by one shared 20x20 multiplier, a two-bit-a-cycle
// square root unit (29 steps, run once per angle and once for a move), a
// 20-step CORDIC and a one-bit-a-cycle divider (16 steps per axis).
// The result sits in an output register; the next item can be taken while
// it waits. If the receiver stalls, a finished second item waits in its last
// state until the output register frees up.
// Reset sets the plane distance to 1.0 and the other registers to zero,
// clears the previous point and falls back to the initial speeds.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "gimbal_aim_angle_speed_split_top_macros.svh"

module gimbal_aim_angle_speed_split_top (
	input  logic                              clk,
	input  logic                              arst_n,
	// Configuration write port.
	input  logic                              cfg_we,
	input  logic [gaas_pkg::CfgAddrW-1:0]     cfg_addr,
	input  logic [gaas_pkg::CfgDataW-1:0]     cfg_wdata,
	// Input stream.
	input  logic                              s_tvalid,
	output logic                              s_tready,
	input  logic [39:0]                       s_tdata,  // target_x, target_y
	// Output stream.
	output logic                              m_tvalid,
	input  logic                              m_tready,
	output logic [63:0]                       m_tdata   // yaw_angle, pitch_angle,
	                                                    // yaw_speed, pitch_speed
);
	import gaas_pkg::*;

	// Configuration registers.
	logic [CoordW-1:0] plane_dist_q;
	logic [SpeedW-1:0] base_speed_q;
	logic [SpeedW-1:0] yaw_init_q;
	logic [SpeedW-1:0] pitch_init_q;

	// Item state.
	state_t state_q, state_d;
	job_t   job_q;
	logic   axis_q;
	logic [4:0] cnt_q;
	logic signed [CoordW-1:0] x_q, y_q, last_x_q, last_y_q;
	logic [CoordW-1:0] ax_q, ay_q;
	logic moved_q, has_moved_q, zero_q;
	logic [SpeedW-1:0] held_yaw_q, held_pitch_q;

	// Shared datapath registers.
	logic [39:0] prod_q, acc_q;
	logic [57:0] rad_q;
	logic [28:0] root_q, dq_q;
	logic [31:0] rem_q;
	logic signed [31:0] nx_q, ny_q;
	logic signed [22:0] z_q;
	logic [15:0] div_lo_q, quo_q;
	logic [AngleW-1:0] yaw_ang_q, pitch_ang_q;

	// Output register.
	logic              m_valid_q;
	logic [63:0]       m_data_q;

	logic accept, out_free;
	logic signed [CoordW-1:0] in_x, in_y, num;
	logic signed [CoordW:0] dx, dy;
	logic [CoordW-1:0] abs_x, abs_y, other_abs;
	logic [CoordW-1:0] mul_a, mul_b;
	logic [39:0] mul_p;
	logic [40:0] sq_sum;
	logic [31:0] sq_rem_sh, sq_trial, sq_rem_n;
	logic sq_ge;
	logic [28:0] sq_root_n;
	logic signed [31:0] cx_sh, cy_sh;
	logic signed [22:0] c_t, z_rnd;
	logic [AngleW-1:0] ang_sat;
	logic [31:0] dv_rem_sh, dv_rem_n;
	logic dv_ge;
	logic [15:0] quo_n;

	assign in_x = s_tdata[19:0];
	assign in_y = s_tdata[39:20];
	assign s_tready = (state_q == ST_IDLE);
	assign accept = s_tvalid && s_tready;
	assign out_free = !m_valid_q || m_tready;
	assign m_tvalid = m_valid_q;
	assign m_tdata = m_data_q;

	// Move from the previous point and its magnitudes.
	assign dx = {in_x[CoordW-1], in_x} - {last_x_q[CoordW-1], last_x_q};
	assign dy = {in_y[CoordW-1], in_y} - {last_y_q[CoordW-1], last_y_q};
	assign abs_x = x_q[CoordW-1] ? CoordW'(-x_q) : CoordW'(x_q);
	assign abs_y = y_q[CoordW-1] ? CoordW'(-y_q) : CoordW'(y_q);
	assign num = (job_q == JOB_YAW) ? x_q : y_q;
	assign other_abs = (job_q == JOB_YAW) ? abs_y : abs_x;

	// Shared multiplier operand selection.
	always_comb begin
		mul_a = plane_dist_q;
		mul_b = plane_dist_q;
		case (state_q)
			ST_MUL_A: begin
				mul_a = (job_q == JOB_SPEED) ? ax_q : plane_dist_q;
				mul_b = mul_a;
			end
			ST_MUL_B: begin
				mul_a = (job_q == JOB_SPEED) ? ay_q : other_abs;
				mul_b = mul_a;
			end
			ST_SPD_MUL: begin
				mul_a = {4'd0, base_speed_q};
				mul_b = axis_q ? ay_q : ax_q;
			end
			default: begin
				mul_a = plane_dist_q;
				mul_b = plane_dist_q;
			end
		endcase
	end
	assign mul_p = mul_a * mul_b;
	assign sq_sum = {1'b0, acc_q} + {1'b0, prod_q};

	// Square root step: two radicand bits per cycle.
	assign sq_rem_sh = {rem_q[29:0], rad_q[57:56]};
	assign sq_trial = {1'b0, root_q, 2'b01};
	assign sq_ge = (sq_rem_sh >= sq_trial);
	assign sq_rem_n = sq_ge ? (sq_rem_sh - sq_trial) : sq_rem_sh;
	assign sq_root_n = {root_q[27:0], sq_ge};

	// CORDIC vectoring step with floor shifts.
	assign cx_sh = nx_q >>> cnt_q;
	assign cy_sh = ny_q >>> cnt_q;
	assign c_t = signed'({3'd0, atan_q20(cnt_q)});

	// Q.20 to Q2.14 rounding with saturation.
	always_comb begin
		z_rnd = (z_q + 23'sd32) >>> 6;
		if (z_rnd > ANG_LIMIT) begin
			ang_sat = AngleW'(ANG_LIMIT);
		end else if (z_rnd < -ANG_LIMIT) begin
			ang_sat = AngleW'(-ANG_LIMIT);
		end else begin
			ang_sat = z_rnd[AngleW-1:0];
		end
	end

	// Restoring division step: one quotient bit per cycle.
	assign dv_rem_sh = {rem_q[30:0], div_lo_q[15]};
	assign dv_ge = (dv_rem_sh >= {3'd0, dq_q});
	assign dv_rem_n = dv_ge ? (dv_rem_sh - {3'd0, dq_q}) : dv_rem_sh;
	assign quo_n = {quo_q[14:0], dv_ge};

	// Sequencer next state.
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE:     if (accept) begin state_d = ST_MUL_A; end
			ST_MUL_A:    state_d = ST_MUL_B;
			ST_MUL_B:    state_d = ST_MUL_SUM;
			ST_MUL_SUM:  state_d = ST_SQRT;
			ST_SQRT: begin
				if (cnt_q == 5'd0) begin
					if (job_q == JOB_SPEED) begin
						state_d = ST_SPD_MUL;
					end else if (sq_root_n == 29'd0 && num == '0) begin
						state_d = ST_ANG_DONE;
					end else begin
						state_d = ST_CORDIC;
					end
				end
			end
			ST_CORDIC:   if (cnt_q == CORDIC_LAST) begin state_d = ST_ANG_DONE; end
			ST_ANG_DONE: begin
				if (job_q == JOB_YAW || moved_q) begin
					state_d = ST_MUL_A;
				end else begin
					state_d = ST_FIN;
				end
			end
			ST_SPD_MUL:  state_d = ST_DIV_LD;
			ST_DIV_LD:   state_d = ST_DIV;
			ST_DIV: begin
				if (cnt_q == 5'd0) begin
					state_d = axis_q ? ST_FIN : ST_SPD_MUL;
				end
			end
			ST_FIN:      if (out_free) begin state_d = ST_IDLE; end
			default:     state_d = ST_IDLE;
		endcase
	end

	// Control state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			job_q <= JOB_YAW;
			axis_q <= 1'b0;
			cnt_q <= '0;
			plane_dist_q <= PLANE_DIST_RESET;
			base_speed_q <= '0;
			yaw_init_q <= '0;
			pitch_init_q <= '0;
			last_x_q <= '0;
			last_y_q <= '0;
			held_yaw_q <= '0;
			held_pitch_q <= '0;
			has_moved_q <= 1'b0;
			m_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			// Register writes.
			if (cfg_we) begin
				case (cfg_addr)
					REG_PLANE_DIST: plane_dist_q <= cfg_wdata;
					REG_BASE_SPEED: base_speed_q <= cfg_wdata[SpeedW-1:0];
					REG_YAW_INIT:   yaw_init_q <= cfg_wdata[SpeedW-1:0];
					REG_PITCH_INIT: pitch_init_q <= cfg_wdata[SpeedW-1:0];
					default: ;
				endcase
			end
			// Output valid: loaded by a finished item, cleared by a result transfer.
			if (state_q == ST_FIN && out_free) begin
				m_valid_q <= 1'b1;
			end else if (m_tready) begin
				m_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						job_q <= JOB_YAW;
						last_x_q <= in_x;
						last_y_q <= in_y;
					end
				end
				ST_MUL_SUM: cnt_q <= SQRT_LAST;
				ST_SQRT: begin
					if (cnt_q != 5'd0) begin
						cnt_q <= cnt_q - 5'd1;
					end else begin
						cnt_q <= '0;
						axis_q <= 1'b0;
					end
				end
				ST_CORDIC: cnt_q <= cnt_q + 5'd1;
				ST_ANG_DONE: job_q <= (job_q == JOB_YAW) ? JOB_PITCH : JOB_SPEED;
				ST_DIV_LD: cnt_q <= DIV_LAST;
				ST_DIV: begin
					if (cnt_q != 5'd0) begin
						cnt_q <= cnt_q - 5'd1;
					end else begin
						if (axis_q) begin
							held_pitch_q <= quo_n;
						end else begin
							held_yaw_q <= quo_n;
						end
						axis_q <= 1'b1;
					end
				end
				ST_FIN: begin
					if (out_free && moved_q) begin
						has_moved_q <= 1'b1;
					end
				end
				default: ;
			endcase
		end
	end

	// Datapath registers.
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				if (accept) begin
					x_q <= in_x;
					y_q <= in_y;
					ax_q <= dx[CoordW] ? CoordW'(-dx) : CoordW'(dx);
					ay_q <= dy[CoordW] ? CoordW'(-dy) : CoordW'(dy);
					moved_q <= (dx != '0) || (dy != '0);
				end
			end
			ST_MUL_A: prod_q <= mul_p;
			ST_MUL_B: begin
				acc_q <= prod_q;
				prod_q <= mul_p;
			end
			ST_MUL_SUM: begin
				rad_q <= {1'b0, sq_sum, 16'd0};
				root_q <= '0;
				rem_q <= '0;
			end
			ST_SQRT: begin
				rad_q <= {rad_q[55:0], 2'b00};
				root_q <= sq_root_n;
				rem_q <= sq_rem_n;
				if (cnt_q == 5'd0) begin
					dq_q <= sq_root_n;
					nx_q <= {3'd0, sq_root_n};
					ny_q <= {{4{num[CoordW-1]}}, num, 8'd0};
					z_q <= '0;
					zero_q <= (sq_root_n == 29'd0) && (num == '0);
				end
			end
			ST_CORDIC: begin
				if (!ny_q[31]) begin
					nx_q <= nx_q + cy_sh;
					ny_q <= ny_q - cx_sh;
					z_q <= z_q + c_t;
				end else begin
					nx_q <= nx_q - cy_sh;
					ny_q <= ny_q + cx_sh;
					z_q <= z_q - c_t;
				end
			end
			ST_ANG_DONE: begin
				if (job_q == JOB_YAW) begin
					yaw_ang_q <= zero_q ? '0 : ang_sat;
				end else begin
					pitch_ang_q <= zero_q ? '0 : ang_sat;
				end
			end
			ST_SPD_MUL: prod_q <= mul_p;
			ST_DIV_LD: begin
				rem_q <= {4'd0, prod_q[35:8]};
				div_lo_q <= {prod_q[7:0], 8'd0};
				quo_q <= '0;
			end
			ST_DIV: begin
				rem_q <= dv_rem_n;
				div_lo_q <= {div_lo_q[14:0], 1'b0};
				quo_q <= quo_n;
			end
			ST_FIN: begin
				if (out_free) begin
					m_data_q[15:0] <= yaw_ang_q;
					m_data_q[31:16] <= pitch_ang_q;
					if (moved_q || has_moved_q) begin
						m_data_q[47:32] <= held_yaw_q;
						m_data_q[63:48] <= held_pitch_q;
					end else begin
						m_data_q[47:32] <= yaw_init_q;
						m_data_q[63:48] <= pitch_init_q;
					end
				end
			end
			default: ;
		endcase
	end

	// The square root remainder never exceeds twice the partial root.
	`GAAS_ASSERT_IMP(a_sqrt_rem, state_q == ST_SQRT, rem_q <= {2'd0, root_q, 1'b0})
	// A split speed never exceeds the base speed.
	`GAAS_ASSERT_IMP(a_div_bound, state_q == ST_DIV && cnt_q == 5'd0, quo_n <= base_speed_q)
	// The CORDIC counter stays within the iteration range.
	`GAAS_ASSERT_IMP(a_cordic_cnt, state_q == ST_CORDIC, cnt_q <= CORDIC_LAST)
	// An accepted item always starts with the first multiply.
	`GAAS_ASSERT_NXT(a_start, accept, state_q == ST_MUL_A && job_q == JOB_YAW)

endmodule

>>> tb/tb.sv
// ----------------------------------------------------------------------------
// Gimbal aim angle and speed split testbench
// Drives target points through the input stream, predicts yaw and pitch angles
// and the split speeds with a bit-exact model, and checks every result transfer
// in order. Registers are rewritten between phases while the block is idle.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb;
	import gaas_pkg::*;

	typedef struct packed {
		logic [15:0] pitch_speed;
		logic [15:0] yaw_speed;
		logic signed [15:0] pitch_angle;
		logic signed [15:0] yaw_angle;
	} aim_result_t;

	localparam int StallLimit = 20000;
	localparam int SettleCycles = 400;

	logic clk;
	logic arst_n;
	logic cfg_we;
	logic [CfgAddrW-1:0] cfg_addr;
	logic [CfgDataW-1:0] cfg_wdata;
	logic s_tvalid;
	logic s_tready;
	logic [39:0] s_tdata;
	logic m_tvalid;
	logic m_tready;
	logic [63:0] m_tdata;

	// Model copy of registers and state.
	logic [19:0] mdl_plane_dist;
	logic [15:0] mdl_base_speed;
	logic [15:0] mdl_yaw_init;
	logic [15:0] mdl_pitch_init;
	longint mdl_last_x;
	longint mdl_last_y;
	logic [15:0] mdl_held_yaw;
	logic [15:0] mdl_held_pitch;
	bit mdl_moved;

	aim_result_t expected_aims[$];
	int error_count;
	int idle_cycles;
	bit calm;
	bit done;

	gimbal_aim_angle_speed_split_top u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_addr  (cfg_addr),
		.cfg_wdata (cfg_wdata),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata)
	);

	always begin
		clk = 1'b0;
		#6;
		clk = 1'b1;
		#6;
	end

	function automatic longint floor_shr(longint v, int s);
		return v >>> s;
	endfunction

	function automatic longint int_sqrt(longint unsigned v);
		longint unsigned res;
		longint unsigned bitv;
		res = 0;
		bitv = 64'd1 << 62;
		while (bitv > v) bitv >>= 2;
		while (bitv != 0) begin
			if (v >= res + bitv) begin
				v -= res + bitv;
				res = (res >> 1) + bitv;
			end else begin
				res >>= 1;
			end
			bitv >>= 2;
		end
		return longint'(res);
	endfunction

	function automatic longint atan_tab_entry(int i);
		case (i)
			0: return 823550;
			1: return 486170;
			2: return 256879;
			3: return 130396;
			4: return 65451;
			5: return 32757;
			6: return 16383;
			default: return longint'(1) << (20 - i);
		endcase
	endfunction

	// Arctangent of num / sqrt(B^2 + other^2) via vectoring CORDIC, Q2.14.
	function automatic logic [15:0] aim_angle(longint num, longint other);
		longint unsigned b;
		longint unsigned o;
		longint r;
		longint ny;
		longint nx;
		longint z;
		longint t;
		longint xs;
		longint ys;
		b = mdl_plane_dist;
		o = (other < 0) ? -other : other;
		r = int_sqrt((b * b + o * o) << 16);
		ny = num * 256;
		nx = r;
		z = 0;
		if (r == 0 && ny == 0) return 16'd0;
		for (int i = 0; i < 20; i++) begin
			t = atan_tab_entry(i);
			xs = floor_shr(nx, i);
			ys = floor_shr(ny, i);
			if (ny >= 0) begin
				nx = nx + ys;
				ny = ny - xs;
				z += t;
			end else begin
				nx = nx - ys;
				ny = ny + xs;
				z -= t;
			end
		end
		z = floor_shr(z + 32, 6);
		if (z > 25736) z = 25736;
		if (z < -25736) z = -25736;
		return z[15:0];
	endfunction

	// Predict the result of one target point and advance the speed state.
	function automatic aim_result_t predict_aim(logic [19:0] tx, logic [19:0] ty);
		aim_result_t res;
		longint x;
		longint y;
		longint unsigned ax;
		longint unsigned ay;
		longint unsigned dq;
		longint unsigned bs;
		x = longint'($signed(tx));
		y = longint'($signed(ty));
		res.yaw_angle = aim_angle(x, y);
		res.pitch_angle = aim_angle(y, x);
		if (x != mdl_last_x || y != mdl_last_y) begin
			ax = (x > mdl_last_x) ? x - mdl_last_x : mdl_last_x - x;
			ay = (y > mdl_last_y) ? y - mdl_last_y : mdl_last_y - y;
			dq = int_sqrt((ax * ax + ay * ay) << 16);
			bs = mdl_base_speed;
			mdl_held_yaw = 16'((bs * ax * 256) / dq);
			mdl_held_pitch = 16'((bs * ay * 256) / dq);
			mdl_moved = 1'b1;
		end
		res.yaw_speed = mdl_moved ? mdl_held_yaw : mdl_yaw_init;
		res.pitch_speed = mdl_moved ? mdl_held_pitch : mdl_pitch_init;
		mdl_last_x = x;
		mdl_last_y = y;
		return res;
	endfunction

	function automatic bit idle_now();
		return !calm && ($urandom_range(99) < 6);
	endfunction

	// Write enable stays high across a run of writes; set_all drops it.
	task automatic write_reg(logic [CfgAddrW-1:0] idx, logic [CfgDataW-1:0] val);
		cfg_we <= 1'b1;
		cfg_addr <= idx;
		cfg_wdata <= val;
		@(posedge clk);
		case (idx)
			REG_PLANE_DIST: mdl_plane_dist = val;
			REG_BASE_SPEED: mdl_base_speed = val[15:0];
			REG_YAW_INIT: mdl_yaw_init = val[15:0];
			REG_PITCH_INIT: mdl_pitch_init = val[15:0];
			default: ;
		endcase
	endtask

	// Valid stays high after a transfer until the next point, an idle cycle or a drain.
	task automatic send_point(logic [19:0] tx, logic [19:0] ty);
		while (idle_now()) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= {ty, tx};
		do @(posedge clk); while (!s_tready);
		expected_aims.push_back(predict_aim(tx, ty));
	endtask

	// Wait until all results are back, then let the block settle.
	task automatic drain();
		s_tvalid <= 1'b0;
		while (expected_aims.size() != 0) @(posedge clk);
		repeat (SettleCycles) @(posedge clk);
	endtask

	task automatic set_all(logic [19:0] bl, logic [15:0] bs, logic [15:0] yi,
			logic [15:0] pi);
		drain();
		write_reg(REG_PLANE_DIST, bl);
		write_reg(REG_BASE_SPEED, {4'd0, bs});
		write_reg(REG_YAW_INIT, {4'd0, yi});
		write_reg(REG_PITCH_INIT, {4'd0, pi});
		cfg_we <= 1'b0;
	endtask

	// Moves and repeated points; a repeated point keeps the held speeds.
	task automatic test_initial_and_hold();
		set_all(20'd256, 16'd1000, 16'd123, 16'd65535);
		send_point(20'd0, 20'd0);
		send_point(20'd0, 20'd0);
		send_point(20'd300, 20'hFFF00);
		send_point(20'd300, 20'hFFF00);
		send_point(20'd1, 20'd0);
	endtask

	// Field extremes and axis-aligned moves.
	task automatic test_extremes();
		set_all(20'hFFFFF, 16'hFFFF, 16'd0, 16'd0);
		send_point(20'h7FFFF, 20'h7FFFF);
		send_point(20'h80000, 20'h80000);
		send_point(20'h80000, 20'h7FFFF);
		send_point(20'h7FFFF, 20'h80000);
		send_point(20'h7FFFF, 20'h00000);
		send_point(20'h7FFFF, 20'hFFFFF);
		set_all(20'd1, 16'd1, 16'd7, 16'd9);
		send_point(20'h80000, 20'd0);
		send_point(20'd0, 20'h7FFFF);
		send_point(20'hFFFFF, 20'hFFFFF);
	endtask

	// Zero plane distance: angles zero at the origin, other points along and off the axes.
	task automatic test_zero_base();
		set_all(20'd0, 16'd500, 16'd1, 16'd2);
		send_point(20'd0, 20'd0);
		send_point(20'd5, 20'd0);
		send_point(20'd0, 20'hFFFFB);
		send_point(20'hFFFFF, 20'd1);
		send_point(20'hFFFFF, 20'd1);
	endtask

	task automatic test_random_points(int count);
		logic [19:0] tx;
		logic [19:0] ty;
		for (int n = 0; n < count; n++) begin
			if ((n % 100) == 0) begin
				set_all(20'($urandom_range(3) == 0 ? $urandom_range(1, 255) : $urandom()),
					16'($urandom()), 16'($urandom()), 16'($urandom()));
				calm = ($urandom_range(3) == 0);
			end
			case ($urandom_range(5))
				0: begin
					tx = mdl_last_x[19:0];
					ty = mdl_last_y[19:0];
				end
				1: begin
					tx = mdl_last_x[19:0] + 20'($signed($urandom_range(8)) - 4);
					ty = mdl_last_y[19:0] + 20'($signed($urandom_range(8)) - 4);
				end
				2: begin
					tx = 20'($signed($urandom_range(4000)) - 2000);
					ty = 20'($signed($urandom_range(4000)) - 2000);
				end
				default: begin
					tx = 20'($urandom());
					ty = 20'($urandom());
				end
			endcase
			send_point(tx, ty);
		end
		calm = 1'b0;
	endtask

	// Receiver side: random stalls and result checking.
	always @(posedge clk) begin
		if (arst_n) begin
			m_tready <= calm || ($urandom_range(99) >= 6);
		end
	end

	always @(posedge clk) begin
		aim_result_t got;
		aim_result_t want;
		if (arst_n && m_tvalid && m_tready) begin
			got = m_tdata;
			if (expected_aims.size() == 0) begin
				$error("unexpected result transfer %h", m_tdata);
				error_count++;
			end else begin
				want = expected_aims.pop_front();
				if (got.yaw_angle !== want.yaw_angle) begin
					$error("yaw_angle expected %0d got %0d", want.yaw_angle, got.yaw_angle);
					error_count++;
				end
				if (got.pitch_angle !== want.pitch_angle) begin
					$error("pitch_angle expected %0d got %0d", want.pitch_angle,
						got.pitch_angle);
					error_count++;
				end
				if (got.yaw_speed !== want.yaw_speed) begin
					$error("yaw_speed expected %0d got %0d", want.yaw_speed, got.yaw_speed);
					error_count++;
				end
				if (got.pitch_speed !== want.pitch_speed) begin
					$error("pitch_speed expected %0d got %0d", want.pitch_speed,
						got.pitch_speed);
					error_count++;
				end
			end
		end
	end

	// Watchdog on cycles without any transfer.
	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || cfg_we || done) begin
			idle_cycles <= 0;
		end else begin
			idle_cycles <= idle_cycles + 1;
			if (idle_cycles > StallLimit) begin
				$display("TB_ERROR");
				$finish;
			end
		end
	end

	initial begin
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_addr = '0;
		cfg_wdata = '0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		m_tready = 1'b0;
		error_count = 0;
		idle_cycles = 0;
		calm = 1'b0;
		done = 1'b0;
		mdl_plane_dist = 20'd256;
		mdl_base_speed = '0;
		mdl_yaw_init = '0;
		mdl_pitch_init = '0;
		mdl_last_x = 0;
		mdl_last_y = 0;
		mdl_held_yaw = '0;
		mdl_held_pitch = '0;
		mdl_moved = 1'b0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		// Reset register values are used before any write.
		send_point(20'd0, 20'd0);
		send_point(20'd256, 20'hFFF00);
		test_initial_and_hold();
		test_extremes();
		test_zero_base();
		test_random_points(780);
		drain();
		done = 1'b1;
		if (error_count == 0) begin
			$display("TB_OK");
		end else begin
			$display("TB_ERROR");
		end
		$finish;
	end

endmodule

>>> sim.f
+incdir+design
design/gaas_pkg.sv
design/gimbal_aim_angle_speed_split_top.sv
tb/tb.sv
